// ===== design/sef_pkg.sv =====
// ----------------------------------------------------------------------------
// sef_pkg
// Shared types and constants for the multi-pixel Sobel edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sef_pkg;

    // Fixed bus geometry: one 64-bit word carries up to eight 8-bit pixels
    localparam int WORD_W     = 64;
    localparam int PIX_W      = 8;
    localparam int WORD_BYTES = WORD_W / PIX_W;

    // Saturation limit of an edge magnitude
    localparam logic [PIX_W-1:0] MAG_MAX = 8'hFF;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [PIX_W-1:0]  t_pix;

    // Control from the top level to the line buffer
    typedef struct packed {
        logic  shift;   // advance the window by one word
        t_word word;    // newest word entering the bottom row
    } t_lb_ctrl;

endpackage

`default_nettype wire

// ===== design/sef_pixel_if.sv =====
// ----------------------------------------------------------------------------
// sef_pixel_if
// Valid/ready channel carrying one word of input pixels per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sef_pixel_if;

    logic                      valid;
    logic                      ready;
    logic [sef_pkg::WORD_W-1:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);

endinterface

`default_nettype wire

// ===== design/sef_edge_if.sv =====
// ----------------------------------------------------------------------------
// sef_edge_if
// Valid/ready channel carrying one word of edge magnitudes per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sef_edge_if;

    logic                      valid;
    logic                      ready;
    logic [sef_pkg::WORD_W-1:0] edge_word;

    modport source (output valid, output edge_word, input ready);
    modport sink   (input valid, input edge_word, output ready);

endinterface

`default_nettype wire

// ===== design/sef_ram.sv =====
// ----------------------------------------------------------------------------
// sef_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module sef_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 158,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/sef_line_buf.sv =====
// ----------------------------------------------------------------------------
// sef_line_buf
// Three-row window registers plus a line store RAM that delays the middle and bottom rows.
// The store is read one position ahead so its data is ready on the shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sef_line_buf #(
    parameter int LANES      = 8,
    parameter int ROW_PIXELS = 1280,
    parameter int REG_WORDS  = (2 * LANES + 1) / LANES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sef_pkg::t_lb_ctrl i_ctrl,
    output logic [2:0][REG_WORDS-1:0][sef_pkg::WORD_W-1:0] o_rows
);

    import sef_pkg::*;

    localparam int REG_PIX   = REG_WORDS * LANES;
    localparam int SW_RAW    = (ROW_PIXELS - REG_PIX + LANES - 1) / LANES;
    localparam int STORE_WORDS = (SW_RAW < 1) ? 1 : SW_RAW;
    localparam int ADDR_W    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(STORE_WORDS - 1);

    logic [2:0][REG_WORDS-1:0][WORD_W-1:0] r_win, n_win;
    logic [ADDR_W-1:0]  r_pos, n_pos, w_rd_addr;
    logic               r_first_lap;
    logic               r_byp;
    logic [2*WORD_W-1:0] r_byp_data;
    logic [2*WORD_W-1:0] w_ram_rd, w_wr_data, w_store;
    logic               w_wrap;

    // Next position in the line store
    assign w_wrap    = (r_pos == LAST_POS);
    assign n_pos     = w_wrap ? '0 : r_pos + 1'b1;
    assign w_rd_addr = i_ctrl.shift ? n_pos : r_pos;

    // Words leaving rows 1 and 2 go back into the store at the current slot
    assign w_wr_data = {r_win[2][0], r_win[1][0]};

    sef_ram #(
        .WIDTH (2 * WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctrl.shift),
        .i_wr_addr (r_pos),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ram_rd)
    );

    // Forward a same-slot write; slots not yet written since reset read as zero
    assign w_store = r_first_lap ? '0 : (r_byp ? r_byp_data : w_ram_rd);

    // Shift every row left by one word
    always_comb begin
        n_win = r_win;
        for (int r = 0; r < 3; r++) begin
            for (int w = 0; w < REG_WORDS - 1; w++) begin
                n_win[r][w] = r_win[r][w + 1];
            end
        end
        n_win[0][REG_WORDS-1] = w_store[WORD_W-1:0];
        n_win[1][REG_WORDS-1] = w_store[2*WORD_W-1:WORD_W];
        n_win[2][REG_WORDS-1] = i_ctrl.word;
    end

    // Advance window, position and first-pass flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_pos       <= '0;
            r_first_lap <= 1'b1;
            r_byp       <= 1'b0;
        end else begin
            r_byp <= i_ctrl.shift && (w_rd_addr == r_pos);
            if (i_ctrl.shift) begin
                r_win <= n_win;
                r_pos <= n_pos;
                if (w_wrap) begin
                    r_first_lap <= 1'b0;
                end
            end
        end
    end

    // Hold the bypassed write data
    always_ff @(posedge i_clk) begin
        r_byp_data <= w_wr_data;
    end

    assign o_rows = r_win;

endmodule

`default_nettype wire

// ===== design/sef_lane.sv =====
// ----------------------------------------------------------------------------
// sef_lane
// Sobel gradient magnitude of one 3x3 window, saturated to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sef_lane (
    input  wire logic [2:0][sef_pkg::PIX_W-1:0] i_top,
    input  wire logic [2:0][sef_pkg::PIX_W-1:0] i_mid,
    input  wire logic [2:0][sef_pkg::PIX_W-1:0] i_bot,
    output logic      [sef_pkg::PIX_W-1:0]      o_mag
);

    import sef_pkg::*;

    logic signed [10:0] w_gx, w_gy;
    logic        [10:0] w_ax, w_ay;
    logic        [11:0] w_sum;

    // Horizontal gradient: right column minus left column
    assign w_gx = ($signed({3'b0, i_top[2]}) - $signed({3'b0, i_top[0]}))
                + ($signed({2'b0, i_mid[2], 1'b0}) - $signed({2'b0, i_mid[0], 1'b0}))
                + ($signed({3'b0, i_bot[2]}) - $signed({3'b0, i_bot[0]}));

    // Vertical gradient: top row minus bottom row
    assign w_gy = ($signed({3'b0, i_top[0]}) + $signed({2'b0, i_top[1], 1'b0})
                 + $signed({3'b0, i_top[2]}))
                - ($signed({3'b0, i_bot[0]}) + $signed({2'b0, i_bot[1], 1'b0})
                 + $signed({3'b0, i_bot[2]}));

    // Absolute values, sum and saturate
    assign w_ax  = w_gx[10] ? 11'(-w_gx) : 11'(w_gx);
    assign w_ay  = w_gy[10] ? 11'(-w_gy) : 11'(w_gy);
    assign w_sum = {1'b0, w_ax} + {1'b0, w_ay};
    assign o_mag = (|w_sum[11:PIX_W]) ? MAG_MAX : w_sum[PIX_W-1:0];

endmodule

`default_nettype wire

// ===== design/sobel_edge_filter_multi_pixel_unit.sv =====
// Path: an accepted word shifts into the window registers; its edge word is then
//   captured in the output register, which drives o_edge, once that register is free.
// Throughput: one word per cycle while o_edge takes its words; the line store RAM is read
//   one slot ahead of the shift and written back in the same cycle on its second port.
// Reset: window rows and store position clear to zero; a first-pass flag makes
//   the line store read as zero until every slot has been written once.
// ----------------------------------------------------------------------------
// sobel_edge_filter_multi_pixel_unit
// Multi-lane 3x3 Sobel edge filter over a streamed 8-bit grayscale image.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_filter_multi_pixel_unit #(
    parameter int LANES      = 8,
    parameter int ROW_PIXELS = 1280
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sef_pixel_if.sink   i_pixel,
    sef_edge_if.source  o_edge
);

    import sef_pkg::*;

    localparam int REG_WORDS = (2 * LANES + 1) / LANES;
    localparam int REG_PIX   = REG_WORDS * LANES;
    localparam int TAP_BASE  = REG_PIX - LANES - 2;
    localparam int NL        = (LANES < WORD_BYTES) ? LANES : WORD_BYTES;

    logic [2:0][REG_WORDS-1:0][WORD_W-1:0] w_rows;
    t_lb_ctrl    w_ctrl;
    logic        w_accept, w_in_ready, w_o_adv;
    logic        r_w_valid, r_o_valid;
    t_word       r_o_edge, w_edge;

    // Two-stage handshake: window stage, then output register
    assign w_o_adv    = r_w_valid && (!r_o_valid || o_edge.ready);
    assign w_in_ready = !r_w_valid || w_o_adv;
    assign w_accept   = i_pixel.valid && w_in_ready;

    assign i_pixel.ready = w_in_ready;
    assign w_ctrl.shift  = w_accept;
    assign w_ctrl.word   = i_pixel.pixel_word;

    sef_line_buf #(
        .LANES      (LANES),
        .ROW_PIXELS (ROW_PIXELS),
        .REG_WORDS  (REG_WORDS)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_rows  (w_rows)
    );

    // Pick each lane's 3x3 window from the row registers
    for (genvar x = 0; x < WORD_BYTES; x++) begin : g_lane
        if (x < NL) begin : g_act
            logic [2:0][2:0][PIX_W-1:0] w_win;
            for (genvar r = 0; r < 3; r++) begin : g_row
                for (genvar k = 0; k < 3; k++) begin : g_col
                    localparam int P = TAP_BASE + x + k;
                    localparam int W = P / LANES;
                    localparam int B = P % LANES;
                    if (B < WORD_BYTES) begin : g_tap
                        assign w_win[r][k] = w_rows[r][W][B*PIX_W +: PIX_W];
                    end else begin : g_zero
                        assign w_win[r][k] = '0;
                    end
                end
            end
            sef_lane u_lane (
                .i_top (w_win[0]),
                .i_mid (w_win[1]),
                .i_bot (w_win[2]),
                .o_mag (w_edge[x*PIX_W +: PIX_W])
            );
        end else begin : g_off
            assign w_edge[x*PIX_W +: PIX_W] = '0;
        end
    end

    // Track stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_w_valid <= w_accept || (r_w_valid && !w_o_adv);
            r_o_valid <= w_o_adv || (r_o_valid && !o_edge.ready);
        end
    end

    // Capture the result word
    always_ff @(posedge i_clk) begin
        if (w_o_adv) begin
            r_o_edge <= w_edge;
        end
    end

    assign o_edge.valid     = r_o_valid;
    assign o_edge.edge_word = r_o_edge;

    // An accepted transaction occupies the window stage next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_w_valid)
        else $error("accepted transaction did not reach the window stage");

    // A waiting window must not shift
    a_window_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_w_valid && !w_o_adv) |=> $stable(w_rows))
        else $error("window changed while its result was waiting");

    // A moved result lands in the output register unchanged
    a_output_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_o_adv |=> (r_o_valid && (r_o_edge == $past(w_edge))))
        else $error("output register did not take the window result");

endmodule

`default_nettype wire

// ===== tb/sobel_edge_filter_multi_pixel_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_filter_multi_pixel_unit_test
// Streams synthetic grayscale images through the multi-lane Sobel filter with
// random idling on both channels, a long output hold-off and a full drain.
// Each edge word is compared with a cycle-free software copy of the filter, or with
// typed-in edges for the directed words.

module sobel_edge_filter_multi_pixel_unit_test;

    import sef_pkg::*;

    localparam int LANES        = 8;
    localparam int ROW_PIXELS   = 1280;
    localparam int WIN_WORDS    = (2 * LANES + 1) / LANES;
    localparam int WIN_PIX      = WIN_WORDS * LANES;
    localparam int STORE_DEPTH  = (ROW_PIXELS - WIN_PIX + LANES - 1) / LANES;
    localparam int TAP_BASE     = WIN_PIX - LANES - 2;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int RUN_LIMIT_NS = 2_000_000;

    // Directed words; edges are typed in only for rows that follow from reset zeros
    typedef struct packed {
        t_word pixels;
        logic  known;
        t_word edges;
    } t_dir_row;

    localparam int DIR_COUNT = 20;
    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        '{64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_FFFF},
        '{64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
        '{64'h0706_0504_0302_0100, 1'b0, 64'h0},
        '{64'hF8F9_FAFB_FCFD_FEFF, 1'b0, 64'h0},
        '{64'h0000_0000_0000_0080, 1'b0, 64'h0},
        '{64'h8000_0000_0000_0000, 1'b0, 64'h0},
        '{64'h00FF_00FF_00FF_00FF, 1'b0, 64'h0},
        '{64'hFF00_FF00_FF00_FF00, 1'b0, 64'h0},
        '{64'h0101_0101_0101_0101, 1'b0, 64'h0},
        '{64'hFEFE_FEFE_FEFE_FEFE, 1'b0, 64'h0},
        '{64'h0102_0408_1020_4080, 1'b0, 64'h0},
        '{64'h7F7F_7F7F_7F7F_7F7F, 1'b0, 64'h0},
        '{64'h8080_8080_8080_8080, 1'b0, 64'h0},
        '{64'h5555_AAAA_5555_AAAA, 1'b0, 64'h0},
        '{64'h0000_0000_0000_0000, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_0000_0000, 1'b0, 64'h0},
        '{64'h0000_0000_FFFF_FFFF, 1'b0, 64'h0}
    };

    // Image content styles for the random part
    typedef enum int {
        PAT_NOISE,
        PAT_SMOOTH,
        PAT_BARS,
        PAT_FLAT,
        PAT_RAMP
    } t_pattern;

    logic i_clk;
    logic i_rst_n;

    sef_pixel_if pix_ch ();
    sef_edge_if  edge_ch ();

    sobel_edge_filter_multi_pixel_unit #(
        .LANES      (LANES),
        .ROW_PIXELS (ROW_PIXELS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pixel (pix_ch),
        .o_edge  (edge_ch)
    );

    // Filter copy: three window rows, two line stores, store position
    t_word       win_rows   [3][WIN_WORDS];
    t_word       line_store [2][STORE_DEPTH];
    int unsigned line_pos;

    t_word       expected_edges [$];
    int unsigned error_count;

    // Source and sink side controls
    logic        offer_known;
    t_word       offer_edges;
    bit          src_idle;
    logic        snk_idle;
    int          hold_reqs;

    // Image generator state
    t_pattern    chunk_mode;
    int          chunk_left;
    int          level;
    bit          bar_hi;
    t_pix        flat_byte;
    t_pix        ramp_step;
    t_pix        ramp_acc;

    // Read one pixel of a window row; columns outside the window return zero
    function automatic int win_pix(input int row, input int p);
        int w;
        int b;
        w = p / LANES;
        b = p % LANES;
        if (b >= WORD_BYTES || w >= WIN_WORDS)
            return 0;
        return int'(win_rows[row][w][8*b +: 8]);
    endfunction

    function automatic void shift_window(input int row, input t_word incoming);
        for (int w = 0; w < WIN_WORDS - 1; w++)
            win_rows[row][w] = win_rows[row][w + 1];
        win_rows[row][WIN_WORDS - 1] = incoming;
    endfunction

    // Advance the filter by one word and return the edge word it yields
    function automatic t_word sobel_step(input t_word word_in);
        int unsigned at;
        t_word       from_store;
        t_word       leaving;
        t_word       result;
        int          c;
        int          gx;
        int          gy;
        int          mag;
        at = (line_pos >= STORE_DEPTH) ? 0 : line_pos;
        for (int r = 0; r < 2; r++) begin
            from_store = line_store[r][at];
            leaving    = win_rows[r + 1][0];
            shift_window(r, from_store);
            line_store[r][at] = leaving;
        end
        shift_window(2, word_in);
        line_pos = (at + 1 >= STORE_DEPTH) ? 0 : at + 1;

        result = '0;
        for (int x = 0; x < LANES && x < WORD_BYTES; x++) begin
            c  = TAP_BASE + x;
            gx = (win_pix(0, c + 2) - win_pix(0, c))
               + 2 * (win_pix(1, c + 2) - win_pix(1, c))
               + (win_pix(2, c + 2) - win_pix(2, c));
            gy = (win_pix(0, c) + 2 * win_pix(0, c + 1) + win_pix(0, c + 2))
               - (win_pix(2, c) + 2 * win_pix(2, c + 1) + win_pix(2, c + 2));
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            result[8*x +: 8] = (mag > int'(MAG_MAX)) ? MAG_MAX : t_pix'(mag);
        end
        return result;
    endfunction

    function automatic void note_error(input string what, input t_word want,
                                       input t_word got);
        error_count++;
        if (error_count <= 10)
            $display("%s: expected %h, got %h", what, want, got);
    endfunction

    // Offer one word, with an optional idle burst ahead of it
    task automatic offer_word(input t_word w, input logic known, input t_word edges);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.pixel_word <= w;
        offer_known       <= known;
        offer_edges       <= edges;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
    endtask

    // Stream image words in chunks of one content style each
    task automatic send_image(input int count);
        t_word w;
        for (int k = 0; k < count; k++) begin
            if (chunk_left == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: chunk_mode = PAT_NOISE;
                    3, 4, 5: chunk_mode = PAT_SMOOTH;
                    6, 7:    chunk_mode = PAT_BARS;
                    8:       chunk_mode = PAT_FLAT;
                    default: chunk_mode = PAT_RAMP;
                endcase
                chunk_left = $urandom_range(8, 200);
                flat_byte  = t_pix'($urandom);
                ramp_step  = t_pix'($urandom_range(0, 12));
            end
            chunk_left--;
            for (int b = 0; b < WORD_BYTES; b++) begin
                case (chunk_mode)
                    PAT_NOISE: begin
                        w[8*b +: 8] = t_pix'($urandom);
                    end
                    PAT_SMOOTH: begin
                        level = level + int'($urandom_range(0, 8)) - 4;
                        if (level < 0)
                            level = 0;
                        if (level > 255)
                            level = 255;
                        w[8*b +: 8] = t_pix'(level);
                    end
                    PAT_BARS: begin
                        if ($urandom_range(0, 3) == 0)
                            bar_hi = !bar_hi;
                        w[8*b +: 8] = bar_hi ? MAG_MAX : 8'h00;
                    end
                    PAT_FLAT: begin
                        w[8*b +: 8] = flat_byte;
                    end
                    default: begin
                        ramp_acc    = ramp_acc + ramp_step;
                        w[8*b +: 8] = ramp_acc;
                    end
                endcase
            end
            offer_word(w, 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the stream hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("** sobel_edge_filter_multi_pixel_unit: FAILED **");
        $finish;
    end

    // Predict on each input transaction, check each output transaction
    always @(posedge i_clk) begin : edge_monitor
        t_word want;
        if (i_rst_n) begin
            if (pix_ch.valid && pix_ch.ready) begin
                want = sobel_step(pix_ch.pixel_word);
                expected_edges.push_back(offer_known ? offer_edges : want);
            end
            if (edge_ch.valid && edge_ch.ready) begin
                if (expected_edges.size() == 0) begin
                    note_error("unexpected edge word", '0, edge_ch.edge_word);
                end else begin
                    want = expected_edges.pop_front();
                    if (edge_ch.edge_word !== want)
                        note_error("edge word mismatch", want, edge_ch.edge_word);
                end
            end
        end
    end

    // Output side: random stalls, one long hold-off per request
    initial begin : edge_sink
        int holds_done;
        holds_done    = 0;
        edge_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_reqs != holds_done) begin
                holds_done++;
                edge_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (snk_idle && $urandom_range(0, 4) == 0) begin
                edge_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            edge_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Input side: reset, directed words, random image phases, drain, verdict
    initial begin : pixel_source
        int waited;
        i_rst_n           = 1'b0;
        pix_ch.valid      = 1'b0;
        pix_ch.pixel_word = '0;
        offer_known       = 1'b0;
        offer_edges       = '0;
        src_idle          = 1'b1;
        snk_idle          = 1'b1;
        hold_reqs         = 0;
        error_count       = 0;
        chunk_left        = 0;
        chunk_mode        = PAT_NOISE;
        level             = 128;
        bar_hi            = 1'b0;
        flat_byte         = '0;
        ramp_step         = '0;
        ramp_acc          = '0;
        line_pos          = 0;
        foreach (win_rows[r, w])
            win_rows[r][w] = '0;
        foreach (line_store[r, a])
            line_store[r][a] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_COUNT; k++)
            offer_word(DIR_ROWS[k].pixels, DIR_ROWS[k].known, DIR_ROWS[k].edges);

        send_image(450);

        // Hold the output off while words keep coming, so the input backs up
        src_idle = 1'b0;
        hold_reqs <= hold_reqs + 1;
        send_image(120);
        src_idle = 1'b1;

        // Pause the input until every edge word is back
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_edges.size() != 0) @(posedge i_clk);

        send_image(300);

        // Closing stretch at full rate
        src_idle = 1'b0;
        snk_idle <= 1'b0;
        send_image(150);
        pix_ch.valid <= 1'b0;

        waited = 0;
        while (expected_edges.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        while (expected_edges.size() != 0)
            note_error("missing edge word", expected_edges.pop_front(), 'x);
        repeat (8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("** sobel_edge_filter_multi_pixel_unit: PASSED **");
        end else begin
            $display("** sobel_edge_filter_multi_pixel_unit: FAILED **");
        end
        $finish;
    end

endmodule
